// ===== hdl/pfe_pkg.sv =====
`timescale 1ns / 1ps

package pfe_pkg;

    localparam int PLACES       = 16;
    localparam int TRANSITIONS  = 16;
    localparam int PLACE_AW     = (PLACES > 1) ? $clog2(PLACES) : 1;
    localparam int WEIGHT_DEPTH = PLACES * TRANSITIONS;
    localparam int WEIGHT_AW    = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
    localparam int CNT_W        = $clog2(PLACES + 1);

    localparam int CMD_W    = 2;
    localparam int TIDX_W   = 4;
    localparam int PIDX_W   = 4;
    localparam int TOKEN_W  = 16;
    localparam int WEIGHT_W = 8;
    localparam int RND_W    = 7;
    localparam int ACT_W    = 7;

    localparam logic [ACT_W-1:0] ACT_RESET = 7'd50;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET_MARKING = 2'd0,
        CMD_SET_INPUT   = 2'd1,
        CMD_SET_OUTPUT  = 2'd2,
        CMD_FIRE        = 2'd3
    } cmd_t;

endpackage

// ===== hdl/pfe_if.sv =====
`timescale 1ns / 1ps

interface pfe_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [pfe_pkg::CMD_W-1:0]   command;
    logic [pfe_pkg::TIDX_W-1:0]  transition_index;
    logic [pfe_pkg::PIDX_W-1:0]  place_index;
    logic [pfe_pkg::TOKEN_W-1:0] load_value;
    logic [pfe_pkg::RND_W-1:0]   random_value;

    modport source (
        output valid, command, transition_index, place_index, load_value, random_value,
        input  ready
    );
    modport sink (
        input  valid, command, transition_index, place_index, load_value, random_value,
        output ready
    );
endinterface

interface pfe_res_if;
    logic valid;
    logic ready;
    logic enabled;
    logic fired;
    logic saturated;

    modport source (
        output valid, enabled, fired, saturated,
        input  ready
    );
    modport sink (
        input  valid, enabled, fired, saturated,
        output ready
    );
endinterface

// ===== hdl/pfe_ram.sv =====
`timescale 1ns / 1ps

module pfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/petri_net_firing_engine.sv =====
`timescale 1ns / 1ps
// A load word's result word is valid in the cycle after the load is accepted; loads run
// one a cycle while the result side takes each result word. A fire word with a valid
// transition index checks enabling in one pass over the places and, when it fires,
// updates the marking in a second read-modify-write pass. After reset a clearing pass
// over all WEIGHT_DEPTH weight addresses writes zero to every token count and weight;
// no word is accepted until it ends.

module petri_net_firing_engine (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [pfe_pkg::ACT_W-1:0] cfg_wdata,
    pfe_cmd_if.sink                   cmd,
    pfe_res_if.source                 res
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_UPDATE
    } state_t;

    state_t                            state_reg, state_next;
    logic [pfe_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic [pfe_pkg::WEIGHT_AW-1:0]     clr_reg, clr_next;
    logic [pfe_pkg::TIDX_W-1:0]        t_reg, t_next;
    logic [pfe_pkg::RND_W-1:0]         rnd_reg, rnd_next;
    logic                              en_reg, en_next;
    logic                              sat_reg, sat_next;
    logic [pfe_pkg::ACT_W-1:0]         act_reg, act_next;
    logic                              res_valid_reg, res_valid_next;
    logic                              res_en_reg, res_en_next;
    logic                              res_fired_reg, res_fired_next;
    logic                              res_sat_reg, res_sat_next;

    logic                              tok_we;
    logic [pfe_pkg::PLACE_AW-1:0]      tok_waddr;
    logic [pfe_pkg::TOKEN_W-1:0]       tok_wdata;
    logic [pfe_pkg::TOKEN_W-1:0]       tok_rdata;
    logic                              in_we;
    logic                              out_we;
    logic [pfe_pkg::WEIGHT_AW-1:0]     w_waddr;
    logic [pfe_pkg::WEIGHT_W-1:0]      w_wdata;
    logic [pfe_pkg::WEIGHT_W-1:0]      in_rdata;
    logic [pfe_pkg::WEIGHT_W-1:0]      out_rdata;

    logic                              accept;
    logic                              t_ok;
    logic                              p_ok;
    logic [pfe_pkg::PLACE_AW-1:0]      ld_p;
    logic [pfe_pkg::WEIGHT_AW-1:0]     ld_waddr;
    logic [pfe_pkg::PLACE_AW-1:0]      rd_p;
    logic [pfe_pkg::PLACE_AW-1:0]      prev_p;
    logic [pfe_pkg::WEIGHT_AW-1:0]     w_raddr;
    logic [pfe_pkg::TOKEN_W:0]         upd_sum;
    logic                              upd_sat;
    logic                              short_now;
    logic                              en_now;
    logic                              fire_ok;
    logic                              have_data;
    logic                              last;
    logic                              clr_tok;
    logic                              clr_last;

    pfe_ram #(.WIDTH(pfe_pkg::TOKEN_W), .DEPTH(pfe_pkg::PLACES)) u_tok_ram (
        .clk   (clk),
        .we    (tok_we),
        .waddr (tok_waddr),
        .wdata (tok_wdata),
        .raddr (rd_p),
        .rdata (tok_rdata)
    );

    pfe_ram #(.WIDTH(pfe_pkg::WEIGHT_W), .DEPTH(pfe_pkg::WEIGHT_DEPTH)) u_in_ram (
        .clk   (clk),
        .we    (in_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .raddr (w_raddr),
        .rdata (in_rdata)
    );

    pfe_ram #(.WIDTH(pfe_pkg::WEIGHT_W), .DEPTH(pfe_pkg::WEIGHT_DEPTH)) u_out_ram (
        .clk   (clk),
        .we    (out_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .raddr (w_raddr),
        .rdata (out_rdata)
    );

    assign cmd.ready     = (state_reg == ST_IDLE) && (!res_valid_reg || res.ready);
    assign accept        = cmd.valid && cmd.ready;
    assign res.valid     = res_valid_reg;
    assign res.enabled   = res_en_reg;
    assign res.fired     = res_fired_reg;
    assign res.saturated = res_sat_reg;

    assign t_ok     = 32'(cmd.transition_index) < 32'(pfe_pkg::TRANSITIONS);
    assign p_ok     = 32'(cmd.place_index) < 32'(pfe_pkg::PLACES);
    assign ld_p     = pfe_pkg::PLACE_AW'(cmd.place_index);
    assign ld_waddr = pfe_pkg::WEIGHT_AW'(int'(cmd.transition_index) * pfe_pkg::PLACES
                                          + int'(cmd.place_index));

    assign rd_p    = pfe_pkg::PLACE_AW'(cnt_reg);
    assign prev_p  = pfe_pkg::PLACE_AW'(cnt_reg - pfe_pkg::CNT_W'(1));
    assign w_raddr = pfe_pkg::WEIGHT_AW'(int'(t_reg) * pfe_pkg::PLACES + int'(rd_p));

    assign clr_tok  = 32'(clr_reg) < 32'(pfe_pkg::PLACES);
    assign clr_last = clr_reg == pfe_pkg::WEIGHT_AW'(pfe_pkg::WEIGHT_DEPTH - 1);

    assign upd_sum = {1'b0, tok_rdata} - (pfe_pkg::TOKEN_W + 1)'(in_rdata)
                     + (pfe_pkg::TOKEN_W + 1)'(out_rdata);
    assign upd_sat = upd_sum[pfe_pkg::TOKEN_W];

    assign have_data = cnt_reg != '0;
    assign last      = cnt_reg == pfe_pkg::CNT_W'(pfe_pkg::PLACES);
    assign short_now = have_data && (tok_rdata < pfe_pkg::TOKEN_W'(in_rdata));
    assign en_now    = en_reg && !short_now;
    assign fire_ok   = ({1'b0, rnd_reg} + (pfe_pkg::RND_W + 1)'(1))
                       < (pfe_pkg::RND_W + 1)'(act_reg);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        clr_next       = clr_reg;
        t_next         = t_reg;
        rnd_next       = rnd_reg;
        en_next        = en_reg;
        sat_next       = sat_reg;
        act_next       = cfg_we ? cfg_wdata : act_reg;
        res_valid_next = res_valid_reg && !res.ready;
        res_en_next    = res_en_reg;
        res_fired_next = res_fired_reg;
        res_sat_next   = res_sat_reg;
        tok_we         = 1'b0;
        tok_waddr      = ld_p;
        tok_wdata      = cmd.load_value;
        in_we          = 1'b0;
        out_we         = 1'b0;
        w_waddr        = ld_waddr;
        w_wdata        = cmd.load_value[pfe_pkg::WEIGHT_W-1:0];

        case (state_reg)
            ST_CLEAR:
            begin
                tok_we    = clr_tok;
                tok_waddr = pfe_pkg::PLACE_AW'(clr_reg);
                tok_wdata = '0;
                in_we     = 1'b1;
                out_we    = 1'b1;
                w_waddr   = clr_reg;
                w_wdata   = '0;
                clr_next  = clr_reg + pfe_pkg::WEIGHT_AW'(1);
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_en_next    = 1'b0;
                    res_fired_next = 1'b0;
                    res_sat_next   = 1'b0;
                    case (pfe_pkg::cmd_t'(cmd.command))
                        pfe_pkg::CMD_SET_MARKING:
                        begin
                            res_valid_next = 1'b1;
                            if (p_ok)
                            begin
                                tok_we = 1'b1;
                            end
                        end
                        pfe_pkg::CMD_SET_INPUT:
                        begin
                            res_valid_next = 1'b1;
                            if (t_ok && p_ok)
                            begin
                                in_we = 1'b1;
                            end
                        end
                        pfe_pkg::CMD_SET_OUTPUT:
                        begin
                            res_valid_next = 1'b1;
                            if (t_ok && p_ok)
                            begin
                                out_we = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (t_ok)
                            begin
                                t_next     = cmd.transition_index;
                                rnd_next   = cmd.random_value;
                                cnt_next   = '0;
                                en_next    = 1'b1;
                                state_next = ST_CHECK;
                            end
                            else
                            begin
                                res_valid_next = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                en_next = en_now;
                if (last)
                begin
                    if (en_now && fire_ok)
                    begin
                        cnt_next   = '0;
                        sat_next   = 1'b0;
                        state_next = ST_UPDATE;
                    end
                    else
                    begin
                        res_valid_next = 1'b1;
                        res_en_next    = en_now;
                        res_fired_next = 1'b0;
                        res_sat_next   = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + pfe_pkg::CNT_W'(1);
                end
            end
            ST_UPDATE:
            begin
                if (have_data)
                begin
                    tok_we    = 1'b1;
                    tok_waddr = prev_p;
                    tok_wdata = upd_sat ? '1 : upd_sum[pfe_pkg::TOKEN_W-1:0];
                    sat_next  = sat_reg || upd_sat;
                end
                if (last)
                begin
                    res_valid_next = 1'b1;
                    res_en_next    = 1'b1;
                    res_fired_next = 1'b1;
                    res_sat_next   = sat_reg || (have_data && upd_sat);
                    state_next     = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + pfe_pkg::CNT_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            clr_reg       <= '0;
            t_reg         <= '0;
            rnd_reg       <= '0;
            en_reg        <= 1'b0;
            sat_reg       <= 1'b0;
            act_reg       <= pfe_pkg::ACT_RESET;
            res_valid_reg <= 1'b0;
            res_en_reg    <= 1'b0;
            res_fired_reg <= 1'b0;
            res_sat_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            clr_reg       <= clr_next;
            t_reg         <= t_next;
            rnd_reg       <= rnd_next;
            en_reg        <= en_next;
            sat_reg       <= sat_next;
            act_reg       <= act_next;
            res_valid_reg <= res_valid_next;
            res_en_reg    <= res_en_next;
            res_fired_reg <= res_fired_next;
            res_sat_reg   <= res_sat_next;
        end
    end

endmodule

// ===== sim/petri_net_firing_engine_test.sv =====
`timescale 1ns / 1ps

module petri_net_firing_engine_test;

    localparam int STALL_LIMIT     = 4000;
    localparam int SETTLE_CYCLES   = 40;
    localparam int PHASE_WORDS     = 235;
    localparam int unsigned TOKEN_MAX = (1 << pfe_pkg::TOKEN_W) - 1;

    typedef struct packed {
        pfe_pkg::cmd_t                command;
        logic [pfe_pkg::TIDX_W-1:0]   transition_index;
        logic [pfe_pkg::PIDX_W-1:0]   place_index;
        logic [pfe_pkg::TOKEN_W-1:0]  load_value;
        logic [pfe_pkg::RND_W-1:0]    random_value;
    } cmd_word_t;

    typedef struct packed {
        logic enabled;
        logic fired;
        logic saturated;
    } outcome_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic [pfe_pkg::ACT_W-1:0]     cfg_wdata;
    logic                          no_gaps;
    int                            error_count;
    int                            stall_cycles;

    pfe_cmd_if cmd_bus ();
    pfe_res_if res_bus ();

    petri_net_firing_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_bus.sink),
        .res       (res_bus.source)
    );

    logic [pfe_pkg::TOKEN_W-1:0]  token_count [pfe_pkg::PLACES];
    logic [pfe_pkg::WEIGHT_W-1:0] input_arc   [pfe_pkg::TRANSITIONS][pfe_pkg::PLACES];
    logic [pfe_pkg::WEIGHT_W-1:0] output_arc  [pfe_pkg::TRANSITIONS][pfe_pkg::PLACES];
    logic [pfe_pkg::ACT_W-1:0]    threshold;

    cmd_word_t pending_words [$];
    outcome_t  expected_outcomes [$];
    cmd_word_t driven_word;

    always #5 clk = ~clk;

    function automatic outcome_t predict_outcome(cmd_word_t w);
        outcome_t    r;
        logic        can_fire;
        int unsigned level;
        r = '0;
        case (w.command)
            pfe_pkg::CMD_SET_MARKING: token_count[w.place_index] = w.load_value;
            pfe_pkg::CMD_SET_INPUT:
                input_arc[w.transition_index][w.place_index] =
                    w.load_value[pfe_pkg::WEIGHT_W-1:0];
            pfe_pkg::CMD_SET_OUTPUT:
                output_arc[w.transition_index][w.place_index] =
                    w.load_value[pfe_pkg::WEIGHT_W-1:0];
            default:
            begin
                can_fire = 1'b1;
                for (int p = 0; p < pfe_pkg::PLACES; p++)
                begin
                    if (token_count[p] < input_arc[w.transition_index][p])
                        can_fire = 1'b0;
                end
                r.enabled = can_fire;
                if (can_fire && (int'(w.random_value) + 1 < int'(threshold)))
                begin
                    r.fired = 1'b1;
                    for (int p = 0; p < pfe_pkg::PLACES; p++)
                    begin
                        level = 32'(token_count[p]) - 32'(input_arc[w.transition_index][p])
                                + 32'(output_arc[w.transition_index][p]);
                        if (level > TOKEN_MAX)
                        begin
                            level = TOKEN_MAX;
                            r.saturated = 1'b1;
                        end
                        token_count[p] = level[pfe_pkg::TOKEN_W-1:0];
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic cmd_word_t random_word();
        cmd_word_t w;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            w.command = pfe_pkg::CMD_FIRE;
        else if (pick < 65)
            w.command = pfe_pkg::CMD_SET_MARKING;
        else if (pick < 85)
            w.command = pfe_pkg::CMD_SET_INPUT;
        else
            w.command = pfe_pkg::CMD_SET_OUTPUT;
        w.transition_index = ($urandom_range(0, 9) < 7)
            ? pfe_pkg::TIDX_W'($urandom_range(0, 3))
            : pfe_pkg::TIDX_W'($urandom_range(0, pfe_pkg::TRANSITIONS - 1));
        w.place_index = ($urandom_range(0, 9) < 6)
            ? pfe_pkg::PIDX_W'($urandom_range(0, 5))
            : pfe_pkg::PIDX_W'($urandom_range(0, pfe_pkg::PLACES - 1));
        w.load_value = pfe_pkg::TOKEN_W'($urandom);
        pick = $urandom_range(0, 99);
        if (w.command == pfe_pkg::CMD_SET_MARKING)
        begin
            if (pick < 33)
                w.load_value = pfe_pkg::TOKEN_W'($urandom_range(0, 30));
            else if (pick < 66)
                w.load_value = pfe_pkg::TOKEN_W'($urandom_range(TOKEN_MAX - 135, TOKEN_MAX));
        end
        else if (w.command != pfe_pkg::CMD_FIRE)
        begin
            if (pick < 35)
                w.load_value[pfe_pkg::WEIGHT_W-1:0] = '0;
            else if (pick < 70)
                w.load_value[pfe_pkg::WEIGHT_W-1:0] = pfe_pkg::WEIGHT_W'($urandom_range(1, 8));
            else if (pick < 85)
                w.load_value[pfe_pkg::WEIGHT_W-1:0] =
                    pfe_pkg::WEIGHT_W'($urandom_range(200, 255));
        end
        w.random_value = ($urandom_range(0, 99) < 85)
            ? pfe_pkg::RND_W'($urandom_range(0, 99))
            : pfe_pkg::RND_W'($urandom_range(0, 127));
        return w;
    endfunction

    task automatic queue_word(pfe_pkg::cmd_t c, int t, int p, int unsigned v, int rnd);
        cmd_word_t w;
        w.command          = c;
        w.transition_index = pfe_pkg::TIDX_W'(t);
        w.place_index      = pfe_pkg::PIDX_W'(p);
        w.load_value       = pfe_pkg::TOKEN_W'(v);
        w.random_value     = pfe_pkg::RND_W'(rnd);
        pending_words.push_back(w);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || cmd_bus.valid || expected_outcomes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(logic [pfe_pkg::ACT_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        threshold = value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic report_mismatch(string field, logic want, logic got);
        error_count++;
        $display("%0t: %s mismatch, expected %0b, actual %0b", $time, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_bus.valid            <= 1'b0;
            cmd_bus.command          <= '0;
            cmd_bus.transition_index <= '0;
            cmd_bus.place_index      <= '0;
            cmd_bus.load_value       <= '0;
            cmd_bus.random_value     <= '0;
        end
        else
        begin
            if (cmd_bus.valid && cmd_bus.ready)
                expected_outcomes.push_back(predict_outcome(driven_word));
            if (!cmd_bus.valid || cmd_bus.ready)
            begin
                if (pending_words.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 13))
                begin
                    driven_word = pending_words.pop_front();
                    cmd_bus.valid            <= 1'b1;
                    cmd_bus.command          <= driven_word.command;
                    cmd_bus.transition_index <= driven_word.transition_index;
                    cmd_bus.place_index      <= driven_word.place_index;
                    cmd_bus.load_value       <= driven_word.load_value;
                    cmd_bus.random_value     <= driven_word.random_value;
                end
                else
                    cmd_bus.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        outcome_t want;
        if (!rst_n)
            res_bus.ready <= 1'b0;
        else
        begin
            if (res_bus.valid && res_bus.ready)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result word, expected none, actual %0b%0b%0b",
                             $time, res_bus.enabled, res_bus.fired, res_bus.saturated);
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (res_bus.enabled !== want.enabled)
                        report_mismatch("enabled", want.enabled, res_bus.enabled);
                    if (res_bus.fired !== want.fired)
                        report_mismatch("fired", want.fired, res_bus.fired);
                    if (res_bus.saturated !== want.saturated)
                        report_mismatch("saturated", want.saturated, res_bus.saturated);
                end
            end
            res_bus.ready <= no_gaps || ($urandom_range(0, 99) >= 13);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no word accepted for %0d cycles", $time, STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        logic [pfe_pkg::ACT_W-1:0] settings [8];
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        no_gaps      = 1'b0;
        error_count  = 0;
        stall_cycles = 0;
        cmd_bus.valid            = 1'b0;
        cmd_bus.command          = '0;
        cmd_bus.transition_index = '0;
        cmd_bus.place_index      = '0;
        cmd_bus.load_value       = '0;
        cmd_bus.random_value     = '0;
        res_bus.ready            = 1'b0;
        for (int p = 0; p < pfe_pkg::PLACES; p++)
        begin
            token_count[p] = '0;
            for (int t = 0; t < pfe_pkg::TRANSITIONS; t++)
            begin
                input_arc[t][p]  = '0;
                output_arc[t][p] = '0;
            end
        end
        threshold = pfe_pkg::ACT_RESET;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The reset threshold stays in force for this first sequence.
        queue_word(pfe_pkg::CMD_SET_MARKING, 0, 0, 16'hFFFF, 0);
        queue_word(pfe_pkg::CMD_SET_MARKING, 0, 15, 16'h0000, 127);
        queue_word(pfe_pkg::CMD_SET_INPUT, 0, 0, 16'hABFF, 0);
        queue_word(pfe_pkg::CMD_SET_OUTPUT, 0, 15, 16'h54FF, 0);
        queue_word(pfe_pkg::CMD_FIRE, 0, 0, 0, 0);
        queue_word(pfe_pkg::CMD_FIRE, 15, 15, 16'hFFFF, 127);
        queue_word(pfe_pkg::CMD_FIRE, 15, 0, 0, 48);
        queue_word(pfe_pkg::CMD_FIRE, 15, 0, 0, 49);
        queue_word(pfe_pkg::CMD_SET_INPUT, 2, 14, 16'h0001, 0);
        queue_word(pfe_pkg::CMD_SET_MARKING, 0, 14, 16'h0000, 0);
        queue_word(pfe_pkg::CMD_FIRE, 2, 0, 0, 0);
        queue_word(pfe_pkg::CMD_SET_OUTPUT, 3, 0, 16'h00FF, 0);
        queue_word(pfe_pkg::CMD_SET_MARKING, 0, 0, 16'hFFFF, 0);
        queue_word(pfe_pkg::CMD_FIRE, 3, 0, 0, 10);
        queue_word(pfe_pkg::CMD_SET_INPUT, 3, 0, 16'h00FF, 0);
        queue_word(pfe_pkg::CMD_FIRE, 3, 0, 0, 0);
        queue_word(pfe_pkg::CMD_SET_MARKING, 0, 7, 16'h5A5A, 0);
        queue_word(pfe_pkg::CMD_SET_INPUT, 15, 7, 16'hFF00, 0);
        queue_word(pfe_pkg::CMD_FIRE, 15, 7, 0, 99);
        queue_word(pfe_pkg::CMD_SET_MARKING, 15, 15, 16'hFFFF, 99);
        queue_word(pfe_pkg::CMD_FIRE, 0, 0, 0, 64);
        wait_drained();

        settings = '{7'd0, 7'd1, 7'd101, 7'd100, 7'd127, 7'd2, 7'd64, 7'd0};
        settings[7] = pfe_pkg::ACT_W'($urandom_range(2, 101));
        for (int phase = 0; phase < 8; phase++)
        begin
            write_threshold(settings[phase]);
            no_gaps = (phase == 3);
            for (int i = 0; i < PHASE_WORDS; i++)
                pending_words.push_back(random_word());
            wait_drained();
        end
        no_gaps = 1'b0;

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/pfe_pkg.sv
hdl/pfe_if.sv
hdl/pfe_ram.sv
hdl/petri_net_firing_engine.sv
sim/petri_net_firing_engine_test.sv
